>>> rtl/ttlc_pkg.sv
package ttlc_pkg;

	// Field widths fixed by the interface
	localparam int unsigned TIME_W   = 63;
	localparam int unsigned ID_W     = 32;
	localparam int unsigned HANDLE_W = 32;
	localparam int unsigned LEN_W    = 24;
	localparam int unsigned TTL_W    = 16;
	localparam int unsigned IDX_W    = 3;

	// Default table depth
	localparam int unsigned DEF_SLOTS = 8;

	// TTL register reset and time base
	localparam logic [TTL_W-1:0] TTL_RESET = 16'd900;
	localparam logic [19:0]      US_PER_S  = 20'd1000000;

	// Expiry threshold in microseconds: (ttl + 1) * 1e6, up to 65536e6
	localparam int unsigned THR_W = 36;
	localparam logic [THR_W-1:0] THR_RESET =
		THR_W'((64'(TTL_RESET) + 64'd1) * 64'(US_PER_S));

	// Status codes
	localparam logic ST_OK   = 1'b0;
	localparam logic ST_MISS = 1'b1;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [TIME_W-1:0]   now_us;
		logic [ID_W-1:0]     entry_id;
		logic [HANDLE_W-1:0] entry_handle;
		logic [LEN_W-1:0]    entry_length;
	} req_t;

	typedef struct packed {
		logic                status;
		logic [IDX_W-1:0]    slot_index;
		logic [ID_W-1:0]     stored_id;
		logic [HANDLE_W-1:0] found_handle;
		logic [LEN_W-1:0]    found_length;
	} rsp_t;

	localparam rsp_t RSP_MISS = '{
		status:       ST_MISS,
		slot_index:   '0,
		stored_id:    '0,
		found_handle: '0,
		found_length: '0
	};

	// One table entry as kept in the slot memory
	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [TIME_W-1:0]   created;
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    length;
	} slot_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXP_RD,
		ST_EXP_AGE,
		ST_EXP_CMP,
		ST_OLD_RD,
		ST_OLD_CMP,
		ST_WRITE,
		ST_LK_RD,
		ST_LK_CMP,
		ST_LK_AGE,
		ST_LK_EXP,
		ST_FIN
	} state_t;

endpackage

>>> rtl/ttl_slot_cache_with_oldest_eviction.sv
// Slot cache with time-to-live expiry and oldest-first eviction.
// Request channel (req_valid/req_ready/req): one insert or lookup per transfer.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one result per request,
// in request order. Config channel (cfg_valid/cfg_ready/cfg_data): writes
// ttl_seconds; always ready, and meant to be written only while idle.
// One 63-bit subtractor is shared by a sequencer that walks the slots one at
// a time through a registered-read slot memory. An insert first walks every
// slot to expire aged entries, then writes the lowest free slot; with the
// table full, a second walk picks the entry with the earliest creation time
// to evict. A lookup walks up to the first valid slot with a matching id and
// then checks that entry's age.
// One request is in flight at a time; req_ready is high only when idle, so
// a new request is taken at the earliest once the response has loaded.
// A finished response sits in an output register; the next request is taken
// while it waits. If the receiver stalls with a response still held, the
// following request completes and then waits before its own response loads.
// Reset clears all valid marks and loads ttl_seconds = 900; slot contents are
// not cleared and need no clearing pass.
module ttl_slot_cache_with_oldest_eviction #(
	parameter int unsigned CACHE_SLOTS = ttlc_pkg::DEF_SLOTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  ttlc_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output ttlc_pkg::rsp_t              rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ttlc_pkg::TTL_W-1:0]  cfg_data
);

	localparam int unsigned IW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(CACHE_SLOTS - 1);
	localparam int unsigned TW = ttlc_pkg::TIME_W;

	ttlc_pkg::state_t state_q, state_d;

	// Control registers
	logic [IW-1:0]          cnt_q, cnt_d;
	logic                   have_free_q, have_free_d;
	logic [CACHE_SLOTS-1:0] slot_valid_q;
	logic                   rsp_valid_q;
	logic [ttlc_pkg::THR_W-1:0] thr_q;

	// Working registers
	ttlc_pkg::req_t   req_q;
	ttlc_pkg::rsp_t   res_q, res_d, rsp_q;
	logic [TW-1:0]    diff_q, diff_d;
	logic             brw_q, brw_d;
	logic [IW-1:0]    free_q, free_d;
	logic [IW-1:0]    best_q, best_d;
	logic [TW-1:0]    best_created_q, best_created_d;
	logic [IW-1:0]    slot_q, slot_d;

	// Slot memory
	ttlc_pkg::slot_t  mem_q [CACHE_SLOTS];
	ttlc_pkg::slot_t  rd_q;
	logic [IW-1:0]    rd_addr;

	// Shared subtractor
	logic [TW-1:0]    sub_a, sub_b;
	logic [TW:0]      sub_res;
	logic             sub_brw;

	// Sequencer strobes
	logic             req_fire;
	logic             advance;
	logic             vclr, vset;
	logic             mem_we;
	logic             fin;
	logic             aged_out;
	logic             keep;

	assign req_ready = (state_q == ttlc_pkg::ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_brw = sub_res[TW];

	// Next read address: step to the next slot or hold the current one
	assign rd_addr = advance ? IW'(cnt_q + 1'b1) : cnt_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttlc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, subtractor operands and strobes
	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		have_free_d    = have_free_q;
		free_d         = free_q;
		best_d         = best_q;
		best_created_d = best_created_q;
		slot_d         = slot_q;
		res_d          = res_q;
		diff_d         = diff_q;
		brw_d          = brw_q;
		sub_a          = '0;
		sub_b          = '0;
		advance        = 1'b0;
		vclr           = 1'b0;
		vset           = 1'b0;
		mem_we         = 1'b0;
		fin            = 1'b0;
		aged_out       = 1'b0;
		keep           = 1'b0;
		unique case (state_q)
			ttlc_pkg::ST_IDLE: begin
				if (req_fire) begin
					cnt_d       = '0;
					have_free_d = 1'b0;
					if (req.op == ttlc_pkg::OP_INSERT) begin
						state_d = ttlc_pkg::ST_EXP_RD;
					end else begin
						state_d = ttlc_pkg::ST_LK_RD;
					end
				end
			end
			ttlc_pkg::ST_EXP_RD: begin
				state_d = ttlc_pkg::ST_EXP_AGE;
			end
			// age = now - created; borrow means time went backwards
			ttlc_pkg::ST_EXP_AGE: begin
				sub_a   = req_q.now_us;
				sub_b   = rd_q.created;
				diff_d  = sub_res[TW-1:0];
				brw_d   = sub_brw;
				state_d = ttlc_pkg::ST_EXP_CMP;
			end
			// expired when age >= (ttl + 1) seconds; track lowest free slot
			ttlc_pkg::ST_EXP_CMP: begin
				sub_a    = diff_q;
				sub_b    = TW'(thr_q);
				aged_out = slot_valid_q[cnt_q] && !brw_q && !sub_brw;
				vclr     = aged_out;
				keep     = slot_valid_q[cnt_q] && !aged_out;
				if (!keep && !have_free_q) begin
					have_free_d = 1'b1;
					free_d      = cnt_q;
				end
				if (cnt_q == LAST) begin
					if (have_free_d) begin
						slot_d  = free_d;
						state_d = ttlc_pkg::ST_WRITE;
					end else begin
						cnt_d   = '0;
						state_d = ttlc_pkg::ST_OLD_RD;
					end
				end else begin
					advance = 1'b1;
					cnt_d   = rd_addr;
					state_d = ttlc_pkg::ST_EXP_AGE;
				end
			end
			ttlc_pkg::ST_OLD_RD: begin
				state_d = ttlc_pkg::ST_OLD_CMP;
			end
			// earliest creation time, strict compare keeps lowest index on ties
			ttlc_pkg::ST_OLD_CMP: begin
				sub_a = rd_q.created;
				sub_b = best_created_q;
				if ((cnt_q == '0) || sub_brw) begin
					best_d         = cnt_q;
					best_created_d = rd_q.created;
				end
				if (cnt_q == LAST) begin
					slot_d  = best_d;
					state_d = ttlc_pkg::ST_WRITE;
				end else begin
					advance = 1'b1;
					cnt_d   = rd_addr;
				end
			end
			ttlc_pkg::ST_WRITE: begin
				mem_we = 1'b1;
				vset   = 1'b1;
				res_d  = '{
					status:       ttlc_pkg::ST_OK,
					slot_index:   ttlc_pkg::IDX_W'(slot_q),
					stored_id:    req_q.entry_id,
					found_handle: '0,
					found_length: '0
				};
				state_d = ttlc_pkg::ST_FIN;
			end
			ttlc_pkg::ST_LK_RD: begin
				state_d = ttlc_pkg::ST_LK_CMP;
			end
			// first valid slot with a matching id
			ttlc_pkg::ST_LK_CMP: begin
				if (slot_valid_q[cnt_q] && (rd_q.id == req_q.entry_id)) begin
					state_d = ttlc_pkg::ST_LK_AGE;
				end else if (cnt_q == LAST) begin
					res_d   = ttlc_pkg::RSP_MISS;
					state_d = ttlc_pkg::ST_FIN;
				end else begin
					advance = 1'b1;
					cnt_d   = rd_addr;
				end
			end
			ttlc_pkg::ST_LK_AGE: begin
				sub_a   = req_q.now_us;
				sub_b   = rd_q.created;
				diff_d  = sub_res[TW-1:0];
				brw_d   = sub_brw;
				state_d = ttlc_pkg::ST_LK_EXP;
			end
			// expired match is dropped and reported as a miss
			ttlc_pkg::ST_LK_EXP: begin
				sub_a = diff_q;
				sub_b = TW'(thr_q);
				if (!brw_q && !sub_brw) begin
					vclr  = 1'b1;
					res_d = ttlc_pkg::RSP_MISS;
				end else begin
					res_d = '{
						status:       ttlc_pkg::ST_OK,
						slot_index:   ttlc_pkg::IDX_W'(cnt_q),
						stored_id:    '0,
						found_handle: rd_q.handle,
						found_length: rd_q.length
					};
				end
				state_d = ttlc_pkg::ST_FIN;
			end
			// hand the result to the output register once it is free
			ttlc_pkg::ST_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					fin     = 1'b1;
					state_d = ttlc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ttlc_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			have_free_q  <= 1'b0;
			slot_valid_q <= '0;
			rsp_valid_q  <= 1'b0;
			thr_q        <= ttlc_pkg::THR_RESET;
		end else begin
			cnt_q       <= cnt_d;
			have_free_q <= have_free_d;
			if (vclr) begin
				slot_valid_q[cnt_q] <= 1'b0;
			end
			if (vset) begin
				slot_valid_q[slot_q] <= 1'b1;
			end
			if (fin) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			// threshold kept in microseconds: (ttl + 1) * 1e6
			if (cfg_valid && cfg_ready) begin
				thr_q <= ttlc_pkg::THR_W'(
					(ttlc_pkg::THR_W'(cfg_data) + 1'b1) *
					ttlc_pkg::THR_W'(ttlc_pkg::US_PER_S));
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req;
		end
		if (fin) begin
			rsp_q <= res_q;
		end
		res_q          <= res_d;
		diff_q         <= diff_d;
		brw_q          <= brw_d;
		free_q         <= free_d;
		best_q         <= best_d;
		best_created_q <= best_created_d;
		slot_q         <= slot_d;
	end

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[slot_q] <= '{
				id:      req_q.entry_id,
				created: req_q.now_us,
				handle:  req_q.entry_handle,
				length:  req_q.entry_length
			};
		end
		rd_q <= mem_q[rd_addr];
	end

	// Eviction scan is entered only with every slot occupied
	a_full_before_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttlc_pkg::ST_OLD_RD) |-> (&slot_valid_q))
		else $error("eviction scan started with a free slot");

	// A written slot is marked valid in the next cycle
	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttlc_pkg::ST_WRITE) |=> slot_valid_q[$past(slot_q)])
		else $error("written slot not marked valid");

	// Inserts always report success
	a_insert_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && (req_q.op == ttlc_pkg::OP_INSERT)) |-> (res_q.status == ttlc_pkg::ST_OK))
		else $error("insert reported a miss");

	// Slot counter stays inside the table
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LAST)
		else $error("slot counter out of range");

	// A response loads only into a free or draining output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |-> !fin)
		else $error("response overwritten while stalled");

endmodule

>>> tb/ttl_slot_cache_with_oldest_eviction_tb.sv
module ttl_slot_cache_with_oldest_eviction_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS = ttlc_pkg::DEF_SLOTS;
	localparam int unsigned CYCLE_LIMIT = 600_000;
	localparam int unsigned PHASE_ITEMS = 155;
	localparam int unsigned POOL_SIZE = 10;
	localparam logic [ttlc_pkg::TIME_W-1:0] T_BASE = 63'd901_000_000;

	// Expected-response tracker: mirrors the slot table and TTL register
	class cache_scoreboard;
		logic [ttlc_pkg::TTL_W-1:0]    ttl_s;
		bit                            live [SLOTS];
		logic [ttlc_pkg::ID_W-1:0]     tag [SLOTS];
		logic [ttlc_pkg::TIME_W-1:0]   born [SLOTS];
		logic [ttlc_pkg::HANDLE_W-1:0] hnd [SLOTS];
		logic [ttlc_pkg::LEN_W-1:0]    len [SLOTS];
		ttlc_pkg::rsp_t                due [$];
		int                            errors;

		function new();
			ttl_s = ttlc_pkg::TTL_RESET;
			errors = 0;
			for (int i = 0; i < SLOTS; i++) begin
				live[i] = 1'b0;
				tag[i] = '0;
				born[i] = '0;
				hnd[i] = '0;
				len[i] = '0;
			end
		endfunction

		function void set_ttl(logic [ttlc_pkg::TTL_W-1:0] v);
			ttl_s = v;
		endfunction

		// Whole-second age past the TTL; a future creation time never expires
		function bit stale(int i, logic [ttlc_pkg::TIME_W-1:0] now);
			logic [63:0] age;
			if (now < born[i])
				return 1'b0;
			age = (64'(now) - 64'(born[i])) / 64'(ttlc_pkg::US_PER_S);
			return age > 64'(ttl_s);
		endfunction

		// Apply one accepted request to the table and queue its response
		function void note_request(ttlc_pkg::req_t r);
			ttlc_pkg::rsp_t e;
			int s;
			bit done;
			e = ttlc_pkg::RSP_MISS;
			s = -1;
			done = 1'b0;
			if (r.op == ttlc_pkg::OP_INSERT) begin
				for (int i = 0; i < SLOTS; i++)
					if (live[i] && stale(i, r.now_us))
						live[i] = 1'b0;
				for (int i = 0; i < SLOTS; i++)
					if (s < 0 && !live[i])
						s = i;
				// full table: oldest creation time goes, lowest index on ties
				if (s < 0) begin
					s = 0;
					for (int i = 1; i < SLOTS; i++)
						if (born[i] < born[s])
							s = i;
				end
				live[s] = 1'b1;
				tag[s] = r.entry_id;
				born[s] = r.now_us;
				hnd[s] = r.entry_handle;
				len[s] = r.entry_length;
				e.status = ttlc_pkg::ST_OK;
				e.slot_index = ttlc_pkg::IDX_W'(s);
				e.stored_id = r.entry_id;
			end else begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!done && live[i] && tag[i] == r.entry_id) begin
						done = 1'b1;
						if (stale(i, r.now_us)) begin
							live[i] = 1'b0;
						end else begin
							e.status = ttlc_pkg::ST_OK;
							e.slot_index = ttlc_pkg::IDX_W'(i);
							e.found_handle = hnd[i];
							e.found_length = len[i];
						end
					end
				end
			end
			due.push_back(e);
		endfunction

		task report(string msg);
			errors++;
			$display("%0t mismatch: %s", $time, msg);
		endtask

		// Compare one response transfer against the oldest expectation
		task check_result(ttlc_pkg::rsp_t got);
			ttlc_pkg::rsp_t want;
			if (due.size() == 0) begin
				report("response with no request outstanding");
				return;
			end
			want = due.pop_front();
			if (got.status !== want.status)
				report($sformatf("status got %0h, expected %0h", got.status, want.status));
			if (got.slot_index !== want.slot_index)
				report($sformatf("slot_index got %0h, expected %0h",
					got.slot_index, want.slot_index));
			if (got.stored_id !== want.stored_id)
				report($sformatf("stored_id got %0h, expected %0h",
					got.stored_id, want.stored_id));
			if (got.found_handle !== want.found_handle)
				report($sformatf("found_handle got %0h, expected %0h",
					got.found_handle, want.found_handle));
			if (got.found_length !== want.found_length)
				report($sformatf("found_length got %0h, expected %0h",
					got.found_length, want.found_length));
		endtask
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        req_valid;
	logic                        req_ready;
	ttlc_pkg::req_t              req;
	logic                        rsp_valid;
	logic                        rsp_ready;
	ttlc_pkg::rsp_t              rsp;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [ttlc_pkg::TTL_W-1:0]  cfg_data;

	cache_scoreboard             sb = new();
	int unsigned                 cycles = 0;
	bit                          quiet = 1'b0;
	bit                          req_noisy = 1'b1;
	logic [ttlc_pkg::TIME_W-1:0] cursor;
	logic [ttlc_pkg::ID_W-1:0]   id_pool [POOL_SIZE];

	ttl_slot_cache_with_oldest_eviction #(
		.CACHE_SLOTS(SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Transfer monitor and run-time limit
	always @(posedge clk) begin
		cycles++;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_ttl(cfg_data);
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Response side: random stall bursts, with calm stretches
	initial begin
		int hold_left;
		bit lively;
		hold_left = 0;
		lively = 1'b1;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (!quiet && lively && $urandom_range(0, 4) == 0) begin
				hold_left = $urandom_range(1, 18) - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
			if ($urandom_range(0, 63) == 0)
				lively = !lively;
		end
	end

	function automatic ttlc_pkg::req_t make_req(ttlc_pkg::op_t op,
			logic [ttlc_pkg::TIME_W-1:0] now, logic [ttlc_pkg::ID_W-1:0] id,
			logic [ttlc_pkg::HANDLE_W-1:0] h, logic [ttlc_pkg::LEN_W-1:0] l);
		ttlc_pkg::req_t r;
		r.op = op;
		r.now_us = now;
		r.entry_id = id;
		r.entry_handle = h;
		r.entry_length = l;
		return r;
	endfunction

	task automatic issue(ttlc_pkg::req_t item);
		@(negedge clk);
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic sender_gap(int n);
		repeat (n) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
	endtask

	// Drop valid and wait for every outstanding response
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_ttl(logic [ttlc_pkg::TTL_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Corner cases at the reset TTL of 900 s
	task automatic directed_items();
		issue(make_req(ttlc_pkg::OP_LOOKUP, '0, '0, '1, '1));
		issue(make_req(ttlc_pkg::OP_INSERT, '0, '1, '1, '1));
		issue(make_req(ttlc_pkg::OP_INSERT, '0, '0, '0, '0));
		// age just under (ttl + 1) s still hits, one microsecond later it expires
		issue(make_req(ttlc_pkg::OP_LOOKUP, 63'd900_999_999, '1, '0, '0));
		issue(make_req(ttlc_pkg::OP_LOOKUP, 63'd901_000_000, '1, '0, '0));
		issue(make_req(ttlc_pkg::OP_LOOKUP, 63'd901_000_000, '0, '0, '0));
		// fill the table, out-of-order times, a tie for oldest, a duplicate id
		issue(make_req(ttlc_pkg::OP_INSERT, T_BASE + 5, 32'h11, $urandom, 24'($urandom)));
		issue(make_req(ttlc_pkg::OP_INSERT, T_BASE + 2, 32'h12, $urandom, 24'($urandom)));
		issue(make_req(ttlc_pkg::OP_INSERT, T_BASE + 2, 32'h13, $urandom, 24'($urandom)));
		issue(make_req(ttlc_pkg::OP_INSERT, T_BASE + 6, 32'h55, $urandom, 24'($urandom)));
		issue(make_req(ttlc_pkg::OP_INSERT, T_BASE + 7, 32'h15, $urandom, 24'($urandom)));
		issue(make_req(ttlc_pkg::OP_INSERT, T_BASE + 7, 32'h55, $urandom, 24'($urandom)));
		issue(make_req(ttlc_pkg::OP_INSERT, T_BASE + 8, 32'h17, $urandom, 24'($urandom)));
		issue(make_req(ttlc_pkg::OP_INSERT, T_BASE + 9, 32'h18, $urandom, 24'($urandom)));
		// two evictions from a full table
		issue(make_req(ttlc_pkg::OP_INSERT, T_BASE + 10, 32'h19, $urandom, 24'($urandom)));
		issue(make_req(ttlc_pkg::OP_INSERT, T_BASE + 10, 32'h1A, $urandom, 24'($urandom)));
		issue(make_req(ttlc_pkg::OP_LOOKUP, T_BASE + 11, 32'h55, '0, '0));
		// time going backwards never expires
		issue(make_req(ttlc_pkg::OP_LOOKUP, T_BASE, 32'h55, '0, '0));
		issue(make_req(ttlc_pkg::OP_INSERT, '1, 32'hA5C3_0F96, $urandom, 24'($urandom)));
		issue(make_req(ttlc_pkg::OP_LOOKUP, '0, 32'hA5C3_0F96, '1, '1));
		issue(make_req(ttlc_pkg::OP_LOOKUP, T_BASE + 12, 32'h12, '0, '0));
	endtask

	// Pick a request time: mostly small steps, some near-TTL and backwards
	function automatic logic [ttlc_pkg::TIME_W-1:0] next_time();
		logic [63:0] span;
		logic [ttlc_pkg::TIME_W-1:0] now;
		int pick;
		int k;
		span = (64'(sb.ttl_s) + 64'd1) * 64'(ttlc_pkg::US_PER_S);
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, SLOTS - 1);
		if (pick < 55) begin
			cursor = cursor + ttlc_pkg::TIME_W'($urandom_range(0, 1_500_000));
			now = cursor;
		end else if (pick < 75) begin
			cursor = cursor + ttlc_pkg::TIME_W'(span / 64'($urandom_range(1, 8)));
			now = cursor;
		end else if (pick < 85) begin
			cursor = cursor + ttlc_pkg::TIME_W'(span) +
				ttlc_pkg::TIME_W'($urandom_range(0, 2_000_000));
			now = cursor;
		end else if (pick < 95) begin
			// right on the expiry edge of some slot
			now = sb.born[k] + ttlc_pkg::TIME_W'(span) -
				ttlc_pkg::TIME_W'($urandom_range(0, 1));
			if (now > cursor)
				cursor = now;
		end else begin
			now = cursor - ttlc_pkg::TIME_W'($urandom_range(0, 3_000_000));
		end
		return now;
	endfunction

	function automatic logic [ttlc_pkg::ID_W-1:0] pick_id();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			return id_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (pick < 85)
			return sb.tag[$urandom_range(0, SLOTS - 1)];
		return $urandom;
	endfunction

	task automatic random_items(int count);
		ttlc_pkg::op_t op;
		logic [ttlc_pkg::TIME_W-1:0] now;
		for (int n = 0; n < count; n++) begin
			if (n % 32 == 0)
				req_noisy = $urandom_range(0, 2) != 0;
			if (!quiet && req_noisy && $urandom_range(0, 3) == 0)
				sender_gap($urandom_range(1, 18));
			op = $urandom_range(0, 1) ? ttlc_pkg::OP_LOOKUP : ttlc_pkg::OP_INSERT;
			now = next_time();
			issue(make_req(op, now, pick_id(), $urandom, 24'($urandom)));
		end
	endtask

	initial begin
		logic [ttlc_pkg::TTL_W-1:0] ttl_plan [6];
		ttl_plan = '{16'd0, 16'hFFFF, 16'd1, 16'd900, 16'd2, 16'd0};
		ttl_plan[5] = 16'($urandom);
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		cursor = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		directed_items();
		drain();

		// random phases, one TTL setting each; the last one runs without idling
		for (int p = 0; p < 6; p++) begin
			write_ttl(ttl_plan[p]);
			cursor = {31'($urandom), 32'($urandom)};
			if ($urandom_range(0, 1))
				cursor[ttlc_pkg::TIME_W-1] = 1'b0;
			for (int i = 0; i < POOL_SIZE; i++)
				id_pool[i] = $urandom;
			quiet = (p == 5);
			random_items(PHASE_ITEMS);
			drain();
		end

		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
